// ===== rtl/smau_pkg.sv =====
// Package for the square matrix arithmetic unit: dimensions, command codes,
// transaction payload structs, the controller state type and sat32. No dependencies.
package smau_pkg;

    localparam int Dim = 4;
    localparam int Cells = Dim * Dim;
    localparam int IdxW = (Dim > 1) ? $clog2(Dim) : 1;
    localparam int CellW = (Cells > 1) ? $clog2(Cells) : 1;
    localparam int AccW = 48 + $clog2(Dim + 1);

    typedef enum logic [2:0] {
        CMD_WRITE_A = 3'd0,
        CMD_WRITE_B = 3'd1,
        CMD_ADD     = 3'd2,
        CMD_SUB     = 3'd3,
        CMD_MUL     = 3'd4,
        CMD_CMP     = 3'd5
    } cmd_t;

    typedef struct packed {
        logic [2:0]         command;
        logic [2:0]         row;
        logic [2:0]         column;
        logic signed [31:0] value;
        logic               write_back;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         out_row;
        logic [2:0]         out_column;
        logic signed [31:0] result_value;
        logic               equal;
        logic               last;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] v);
        if (v > AccW'(signed'(32'sh7fffffff))) return 32'sh7fffffff;
        if (v < AccW'(signed'(32'sh80000000))) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

// ===== rtl/square_matrix_arithmetic_unit.sv =====
// Top level of the square matrix arithmetic unit: matrices, controller and
// the row of MAC cells. Depends on smau_pkg and smau_cell.
//
// The unit holds two Dim-by-Dim signed Q16.16 matrices A and B, zero after
// reset. An element write emits nothing. Add and subtract emit one output
// transaction per element. Multiply processes one result row at a time: a
// row of Dim multiply-accumulate cells, one per column, takes one k step per
// cycle, so a row is accumulated over all k steps and then emitted element by
// element. Compare scans one element per cycle while no earlier result waits
// in the output register, and emits one transaction. A new transaction is
// accepted only once the previous command has loaded its last result into the
// output register; products accumulate unsaturated and are saturated to 32
// bits once at the end, with write-back applied only after the final element
// so every result is formed from the old A and B.
module square_matrix_arithmetic_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  smau_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output smau_pkg::out_item_t  m_data
);
    localparam int D = smau_pkg::Dim;
    localparam int IW = smau_pkg::IdxW;
    localparam int CW = smau_pkg::CellW;
    localparam int AW = smau_pkg::AccW;

    logic signed [31:0] a_reg [smau_pkg::Cells];
    logic signed [31:0] b_reg [smau_pkg::Cells];
    logic signed [31:0] res_reg [smau_pkg::Cells];

    smau_pkg::state_t state_reg, state_next;
    smau_pkg::cmd_t   cmd_reg;
    logic             wb_reg;
    logic [IW-1:0]    i_reg, k_reg, j_reg;
    logic             eq_reg;
    logic             m_valid_reg;
    smau_pkg::out_item_t m_data_reg;

    logic accept, take;
    logic signed [AW-1:0] acc [D];
    logic cell_clear, cell_en;

    assign accept = s_valid && s_ready;
    assign take   = m_valid_reg && m_ready;
    assign s_ready = (state_reg == smau_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    function automatic logic [CW-1:0] ix(input logic [IW-1:0] r, input logic [IW-1:0] c);
        return CW'(int'(r) * D + int'(c));
    endfunction

    logic is_arith, wr_cmd;
    assign wr_cmd = s_data.command == smau_pkg::CMD_WRITE_A ||
                    s_data.command == smau_pkg::CMD_WRITE_B;
    assign is_arith = s_data.command == smau_pkg::CMD_ADD ||
                      s_data.command == smau_pkg::CMD_SUB ||
                      s_data.command == smau_pkg::CMD_MUL ||
                      s_data.command == smau_pkg::CMD_CMP;

    logic last_i, last_k, last_j;
    assign last_i = (i_reg == IW'(D - 1));
    assign last_k = (k_reg == IW'(D - 1));
    assign last_j = (j_reg == IW'(D - 1));

    // Next-state logic. RUN accumulates a product row; EMIT walks elements.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            smau_pkg::ST_IDLE: begin
                if (accept && is_arith) begin
                    state_next = (s_data.command == smau_pkg::CMD_MUL) ?
                                 smau_pkg::ST_RUN : smau_pkg::ST_EMIT;
                end
            end
            smau_pkg::ST_RUN: begin
                if (last_k) state_next = smau_pkg::ST_EMIT;
            end
            smau_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    if (cmd_reg == smau_pkg::CMD_CMP) begin
                        if (last_i && last_j) state_next = smau_pkg::ST_IDLE;
                    end else if (last_j) begin
                        if (!last_i) state_next = (cmd_reg == smau_pkg::CMD_MUL) ?
                                                  smau_pkg::ST_RUN : smau_pkg::ST_EMIT;
                        else state_next = smau_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = smau_pkg::ST_IDLE;
        endcase
    end

    // Output-side control toward the cells.
    always_comb begin
        cell_clear = 1'b0;
        cell_en    = 1'b0;
        unique case (state_reg)
            smau_pkg::ST_IDLE: cell_clear = 1'b1;
            smau_pkg::ST_RUN:  cell_en = 1'b1;
            smau_pkg::ST_EMIT: cell_clear = (!m_valid_reg || m_ready) && last_j;
            default: cell_clear = 1'b1;
        endcase
    end

    for (genvar g = 0; g < D; g++) begin : g_cells
        smau_cell u_cell (
            .aclk   (aclk),
            .clear  (cell_clear),
            .mac_en (cell_en),
            .a_in   (a_reg[ix(i_reg, k_reg)]),
            .b_in   (b_reg[ix(k_reg, IW'(g))]),
            .acc    (acc[g])
        );
    end

    logic signed [31:0] elem;
    logic [CW-1:0] n_cur;
    assign n_cur = ix(i_reg, j_reg);
    always_comb begin
        logic signed [AW-1:0] sa, sb;
        sa = AW'(a_reg[n_cur]);
        sb = AW'(b_reg[n_cur]);
        unique case (cmd_reg)
            smau_pkg::CMD_ADD: elem = smau_pkg::sat32(sa + sb);
            smau_pkg::CMD_SUB: elem = smau_pkg::sat32(sa - sb);
            default:           elem = smau_pkg::sat32(acc[j_reg]);
        endcase
    end

    logic step, load;
    assign step = (state_reg == smau_pkg::ST_EMIT) && (!m_valid_reg || m_ready);
    // Every element step loads a result, except the inner steps of a compare.
    assign load = step && (cmd_reg != smau_pkg::CMD_CMP || (last_i && last_j));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= smau_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            i_reg <= '0; j_reg <= '0; k_reg <= '0;
            eq_reg <= 1'b1; wb_reg <= 1'b0;
            cmd_reg <= smau_pkg::CMD_ADD;
            for (int n = 0; n < smau_pkg::Cells; n++) begin
                a_reg[n] <= '0;
                b_reg[n] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (take && !load) m_valid_reg <= 1'b0;
            if (accept) begin
                i_reg <= '0; j_reg <= '0; k_reg <= '0; eq_reg <= 1'b1;
                wb_reg <= s_data.write_back && s_data.command != smau_pkg::CMD_CMP;
                if (is_arith) cmd_reg <= smau_pkg::cmd_t'(s_data.command);
                if (wr_cmd && 32'(s_data.row) < D && 32'(s_data.column) < D) begin
                    if (s_data.command == smau_pkg::CMD_WRITE_A)
                        a_reg[ix(IW'(s_data.row), IW'(s_data.column))] <= s_data.value;
                    else
                        b_reg[ix(IW'(s_data.row), IW'(s_data.column))] <= s_data.value;
                end
            end
            if (state_reg == smau_pkg::ST_RUN) k_reg <= last_k ? '0 : k_reg + 1'b1;
            if (step) begin
                j_reg <= last_j ? '0 : j_reg + 1'b1;
                if (last_j) i_reg <= i_reg + 1'b1;
                if (cmd_reg == smau_pkg::CMD_CMP) begin
                    if (a_reg[n_cur] != b_reg[n_cur]) eq_reg <= 1'b0;
                    if (last_i && last_j) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= '{3'd0, 3'd0, 32'sd0,
                                         eq_reg && (a_reg[n_cur] == b_reg[n_cur]), 1'b1};
                    end
                end else begin
                    m_valid_reg <= 1'b1;
                    m_data_reg  <= '{3'(i_reg), 3'(j_reg), elem, 1'b0, last_i && last_j};
                    res_reg[n_cur] <= elem;
                    if (last_i && last_j && wb_reg) begin
                        for (int n = 0; n < smau_pkg::Cells - 1; n++) a_reg[n] <= res_reg[n];
                        a_reg[n_cur] <= elem;
                    end
                end
            end
        end
    end

    // Cells are cleared whenever the controller waits for a command.
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == smau_pkg::ST_IDLE |-> cell_clear && !cell_en)
        else $error("cells not held clear while idle");
    a_run_k: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == smau_pkg::ST_RUN && !last_k |=> state_reg == smau_pkg::ST_RUN)
        else $error("product row left before all k steps");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(m_data_reg))
        else $error("pending result changed");
endmodule

// ===== rtl/smau_cell.sv =====
// One multiply-accumulate cell of the row; owns column j of the current row.
// Depends on smau_pkg.
module smau_cell (
    input  logic                      aclk,
    input  logic                      clear,
    input  logic                      mac_en,
    input  logic signed [31:0]        a_in,
    input  logic signed [31:0]        b_in,
    output logic signed [smau_pkg::AccW-1:0] acc
);
    logic signed [63:0] prod;
    logic signed [smau_pkg::AccW-1:0] acc_reg;

    // Arithmetic right shift truncates toward minus infinity.
    assign prod = 64'(a_in) * 64'(b_in);

    always_ff @(posedge aclk) begin
        if (clear) begin
            acc_reg <= '0;
        end else if (mac_en) begin
            acc_reg <= acc_reg + smau_pkg::AccW'(prod >>> 16);
        end
    end

    assign acc = acc_reg;
endmodule
